// ===== rtl/dsp_pkg.sv =====
`timescale 1ns / 1ps
package dsp_pkg;
  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int DIST_W = 10;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_STOP   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_TIMER  = 2'd3;

  localparam logic [1:0] SENS_LEFT  = 2'd0;
  localparam logic [1:0] SENS_RIGHT = 2'd1;
  localparam logic [1:0] SENS_FRONT = 2'd2;

  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;
  localparam logic [1:0] SERVO_OTHER = 2'd3;

  localparam logic [1:0] TGT_MOTOR = 2'd0;
  localparam logic [1:0] TGT_SERVO = 2'd1;
  localparam logic [1:0] TGT_TIMER = 2'd2;

  localparam logic [1:0] MOT_STOP  = 2'd0;
  localparam logic [1:0] MOT_START = 2'd1;
  localparam logic [1:0] MOT_BACK  = 2'd2;
  localparam logic [1:0] MOT_FWD   = 2'd3;

  localparam logic [3:0] SV_CENTER  = 4'd0;
  localparam logic [3:0] SV_RIGHT   = 4'd1;
  localparam logic [3:0] SV_LEFT    = 4'd2;
  localparam logic [3:0] SV_TURN_R  = 4'd3;
  localparam logic [3:0] SV_TURN_L  = 4'd4;
  localparam logic [3:0] SV_3PT_R   = 4'd5;
  localparam logic [3:0] SV_3PT_L   = 4'd6;
  localparam logic [3:0] SV_NUDGE_R = 4'd7;
  localparam logic [3:0] SV_NUDGE_L = 4'd8;

  localparam logic [1:0] CFG_TURN_SPEED     = 2'd0;
  localparam logic [1:0] CFG_STRAIGHT_SPEED = 2'd1;
  localparam logic [1:0] CFG_TURN_DURATION  = 2'd2;
  localparam logic [1:0] CFG_TURN_MODE      = 2'd3;

  localparam logic [9:0] NO_FRONT       = 10'd200;
  localparam logic [9:0] TURN_FRONT_LIM = 10'd60;
  localparam logic [9:0] REVERSE_LIM    = 10'd11;
  localparam logic [9:0] NUDGE_LIM      = 10'd10;
  localparam logic [9:0] SPEED_SWITCH   = 10'd70;
  localparam logic [9:0] REVERSE_ARG    = 10'd50;
  localparam logic [9:0] REVERSE_MS     = 10'd1000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] sensor;
    logic [9:0] distance;
    logic [1:0] motor_direction;
    logic [1:0] servo_activity;
  } in_item_t;

  typedef struct packed {
    logic [1:0] target;
    logic [1:0] motor_command;
    logic [3:0] servo_command;
    logic [9:0] argument;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic clear;     // start: empty windows
    logic push;      // push sample into its window
    logic div_start; // begin both average divisions
    logic commit;    // update flags / front after decision
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_sts_t;
endpackage

// ===== rtl/dsp_div.sv =====
`timescale 1ns / 1ps
module dsp_div #(
  parameter int NUM_W = 14,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W+1:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = '0;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      d_nxt = den;
      cnt_nxt = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[NUM_W-1]};
      if (trial >= {2'b00, d_r}) begin
        trial = trial - {2'b00, d_r};
        q_nxt = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        q_nxt = {q_r[NUM_W-2:0], 1'b0};
      end
      rem_nxt = trial[DEN_W:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign quo = q_r;
  assign done = busy_r && (cnt_r == CW'(1));
endmodule

// ===== rtl/dsp_datapath.sv =====
`timescale 1ns / 1ps
module dsp_datapath #(
  parameter int WINDOW_DEPTH = dsp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsp_pkg::dp_cmd_t  cmd,
  output dsp_pkg::dp_sts_t  sts,
  input  dsp_pkg::in_item_t in_item,
  input  logic [7:0]        turn_speed,
  input  logic [7:0]        straight_speed,
  input  logic [7:0]        turn_duration,
  input  logic              turn_mode,
  output dsp_pkg::out_item_t res [4],
  output logic [2:0]        res_n
);
  localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = 10 + CW;

  dsp_pkg::in_item_t it_r;
  logic [9:0]  lwin_r [WINDOW_DEPTH];
  logic [9:0]  rwin_r [WINDOW_DEPTH];
  logic [PW-1:0] lpos_r, rpos_r, lnew_r, rnew_r;
  logic [CW-1:0] lcnt_r, rcnt_r;
  logic [SW-1:0] lsum_r, rsum_r;
  logic [9:0]  front_r;
  logic        halted_r, slow_r, armed_r;
  logic [SW-1:0] lavg, ravg;
  logic        ldone, rdone;
  logic        is_left, is_side, accepted, push_en;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == PW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign is_left = (it_r.sensor == dsp_pkg::SENS_LEFT);
  assign is_side = (it_r.opcode == dsp_pkg::OP_SAMPLE) &&
                   (it_r.sensor == dsp_pkg::SENS_LEFT ||
                    it_r.sensor == dsp_pkg::SENS_RIGHT);
  assign accepted = (it_r.motor_direction == dsp_pkg::DIR_FWD ||
                     it_r.motor_direction == dsp_pkg::DIR_BACK) &&
                    it_r.servo_activity != dsp_pkg::SERVO_OTHER && !halted_r;
  assign push_en = cmd.push && accepted && is_side;

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (push_en && is_left) lwin_r[lpos_r] <= it_r.distance;
    if (push_en && !is_left) rwin_r[rpos_r] <= it_r.distance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r <= '0; rpos_r <= '0; lnew_r <= '0; rnew_r <= '0;
      lcnt_r <= '0; rcnt_r <= '0; lsum_r <= '0; rsum_r <= '0;
      front_r <= dsp_pkg::NO_FRONT;
      halted_r <= 1'b1; slow_r <= 1'b0; armed_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        lpos_r <= '0; rpos_r <= '0;
        lcnt_r <= '0; rcnt_r <= '0; lsum_r <= '0; rsum_r <= '0;
        front_r <= dsp_pkg::NO_FRONT;
      end
      if (push_en) begin
        if (is_left) begin
          lsum_r <= lsum_r + SW'(it_r.distance)
                    - ((lcnt_r == CW'(WINDOW_DEPTH)) ? SW'(lwin_r[lpos_r]) : '0);
          if (lcnt_r != CW'(WINDOW_DEPTH)) lcnt_r <= lcnt_r + 1'b1;
          lnew_r <= lpos_r;
          lpos_r <= inc(lpos_r);
        end else begin
          rsum_r <= rsum_r + SW'(it_r.distance)
                    - ((rcnt_r == CW'(WINDOW_DEPTH)) ? SW'(rwin_r[rpos_r]) : '0);
          if (rcnt_r != CW'(WINDOW_DEPTH)) rcnt_r <= rcnt_r + 1'b1;
          rnew_r <= rpos_r;
          rpos_r <= inc(rpos_r);
        end
      end
      if (cmd.commit) begin
        case (it_r.opcode)
          dsp_pkg::OP_STOP:  halted_r <= 1'b1;
          dsp_pkg::OP_START: halted_r <= 1'b0;
          dsp_pkg::OP_TIMER: armed_r <= 1'b0;
          default: begin
            if (accepted && it_r.sensor == dsp_pkg::SENS_FRONT &&
                it_r.distance != '0) begin
              front_r <= it_r.distance;
              if (it_r.distance <= dsp_pkg::REVERSE_LIM) armed_r <= 1'b1;
              if (it_r.distance < dsp_pkg::SPEED_SWITCH) slow_r <= 1'b1;
              else slow_r <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  dsp_div #(.NUM_W(SW), .DEN_W(CW)) u_ldiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(lsum_r), .den(lcnt_r),
    .quo(lavg), .done(ldone)
  );
  dsp_div #(.NUM_W(SW), .DEN_W(CW)) u_rdiv (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(rsum_r), .den(rcnt_r),
    .quo(ravg), .done(rdone)
  );
  assign sts.div_done = ldone && rdone;

  logic [9:0] lnewest, rnewest, lval, rval, m;
  logic [SW+3:0] dl, dr;
  logic dep_l, dep_r, turn;
  assign m = it_r.distance;
  assign lnewest = (lcnt_r == '0) ? '0 : lwin_r[lnew_r];
  assign rnewest = (rcnt_r == '0) ? '0 : rwin_r[rnew_r];
  assign lval = is_left ? m : lnewest;
  assign rval = is_left ? rnewest : m;

  always_comb begin
    dl = (SW+4)'(lval) > (SW+4)'(lavg) ? (SW+4)'(lval) - (SW+4)'(lavg)
                                       : (SW+4)'(lavg) - (SW+4)'(lval);
    dr = (SW+4)'(rval) > (SW+4)'(ravg) ? (SW+4)'(rval) - (SW+4)'(ravg)
                                       : (SW+4)'(ravg) - (SW+4)'(rval);
    dep_l = ((dl << 3) + (dl << 1)) > (((SW+4)'(lavg) << 1) + (SW+4)'(lavg));
    dep_r = ((dr << 3) + (dr << 1)) > (((SW+4)'(ravg) << 1) + (SW+4)'(ravg));
    turn = ((lval != '0) || (rval != '0)) && (dep_l || dep_r) &&
           (front_r < dsp_pkg::TURN_FRONT_LIM);
  end

  dsp_pkg::out_item_t r [4];
  logic [2:0] n;

  function automatic dsp_pkg::out_item_t mk(input logic [1:0] t, input logic [1:0] mc,
                                           input logic [3:0] sc, input logic [9:0] a);
    mk = '{target: t, motor_command: mc, servo_command: sc, argument: a, last: 1'b0};
  endfunction

  always_comb begin
    for (int i = 0; i < 4; i++) r[i] = '0;
    n = '0;
    case (it_r.opcode)
      dsp_pkg::OP_STOP: begin
        r[0] = mk(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, '0);
        n = 3'd1;
      end
      dsp_pkg::OP_START: begin
        r[0] = mk(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, '0);
        r[1] = mk(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_START, dsp_pkg::SV_CENTER,
                  {2'b00, straight_speed});
        n = 3'd2;
      end
      dsp_pkg::OP_TIMER: begin
        if (armed_r) begin
          r[0] = mk(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_FWD, dsp_pkg::SV_CENTER,
                    {2'b00, turn_speed});
          r[1] = mk(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, '0);
          n = 3'd2;
        end
      end
      default: begin
        if (accepted && it_r.sensor == dsp_pkg::SENS_FRONT && m != '0) begin
          if (m <= dsp_pkg::REVERSE_LIM) begin
            r[0] = mk(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_BACK, dsp_pkg::SV_CENTER,
                      {2'b00, turn_speed});
            r[1] = mk(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                      (lnewest > rnewest) ? dsp_pkg::SV_RIGHT : dsp_pkg::SV_LEFT,
                      dsp_pkg::REVERSE_ARG);
            r[2] = mk(dsp_pkg::TGT_TIMER, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER,
                      dsp_pkg::REVERSE_MS);
            n = 3'd3;
          end
          if ((m < dsp_pkg::SPEED_SWITCH && !slow_r) ||
              (m >= dsp_pkg::SPEED_SWITCH && slow_r)) begin
            r[n[1:0]] = mk(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_FWD, dsp_pkg::SV_CENTER,
                           {2'b00, slow_r ? straight_speed : turn_speed});
            n = n + 3'd1;
          end
        end else if (accepted && (it_r.sensor == dsp_pkg::SENS_LEFT ||
                                  it_r.sensor == dsp_pkg::SENS_RIGHT)) begin
          if ((is_left ? rcnt_r : lcnt_r) != '0) begin
            if (turn) begin
              r[0] = mk(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                        (rval > lval) ? (turn_mode ? dsp_pkg::SV_3PT_R : dsp_pkg::SV_TURN_R)
                                      : (turn_mode ? dsp_pkg::SV_3PT_L : dsp_pkg::SV_TURN_L),
                        turn_mode ? '0 : {2'b00, turn_duration});
              n = 3'd1;
            end else if (m >= 10'd1 && m <= dsp_pkg::NUDGE_LIM) begin
              r[0] = mk(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                        is_left ? dsp_pkg::SV_NUDGE_R : dsp_pkg::SV_NUDGE_L, '0);
              n = 3'd1;
            end
          end
        end
      end
    endcase
    for (int i = 0; i < 4; i++) if (3'(i + 1) == n) r[i].last = 1'b1;
  end

  assign res = r;
  assign res_n = n;
endmodule

// ===== rtl/dsp_ctrl.sv =====
`timescale 1ns / 1ps
module dsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dsp_pkg::out_item_t out_item,
  output dsp_pkg::dp_cmd_t   cmd,
  input  dsp_pkg::dp_sts_t   sts,
  input  dsp_pkg::out_item_t res [4],
  input  logic [2:0]         res_n
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUSH = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  dsp_pkg::out_item_t buf_r [4];
  dsp_pkg::out_item_t obuf_r, obuf_nxt;
  logic ov_r, ov_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    obuf_nxt = obuf_r;
    ov_nxt = ov_r;
    cmd = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        cmd.clear = in_item.opcode == dsp_pkg::OP_START;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (sts.div_done) state_nxt = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        cnt_nxt = res_n;
        idx_nxt = '0;
        state_nxt = (res_n == '0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: if (!ov_nxt) begin
        obuf_nxt = buf_r[idx_r];
        ov_nxt = 1'b1;
        idx_nxt = idx_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 3'd1) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    obuf_r <= obuf_nxt;
    if (state_r == S_COMMIT) buf_r <= res;
  end

  assign out_valid = ov_r;
  assign out_item = obuf_r;
endmodule

// ===== rtl/distance_steering_policy.sv =====
`timescale 1ns / 1ps
// Distance steering policy.
// Input channel in_valid/in_ready/in_item carries one event beat: stop,
// start, distance sample or reverse-timer expiry. Output channel
// out_valid/out_ready/out_item carries zero to four command beats per
// event; the final beat of an event has last set.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the four
// registers; cfg_ready is always high. Write only when idle.
// An event passes through accept, window push, divider start, 14
// window-average divider steps (one per sum bit at default depth) and
// commit; its command beats then follow in order as the receiver takes them.
// The first command beat is loaded into the output register in the emit state.
// One event is handled at a time; in_ready is high only between events.
// A stalled receiver holds the current beat in the output register and
// the block waits before presenting the next one.
// Reset: halted, windows empty, no front reading (200), speed flag and
// timer flag clear, registers at 1, 3, 30 and 0.
module distance_steering_policy #(
  parameter int WINDOW_DEPTH = dsp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dsp_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  logic [7:0] turn_speed_r, straight_speed_r, turn_duration_r;
  logic       turn_mode_r;
  dsp_pkg::dp_cmd_t cmd;
  dsp_pkg::dp_sts_t sts;
  dsp_pkg::out_item_t res [4];
  logic [2:0] res_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_speed_r <= 8'd1;
      straight_speed_r <= 8'd3;
      turn_duration_r <= 8'd30;
      turn_mode_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          dsp_pkg::CFG_TURN_SPEED:     turn_speed_r <= cfg_data;
          dsp_pkg::CFG_STRAIGHT_SPEED: straight_speed_r <= cfg_data;
          dsp_pkg::CFG_TURN_DURATION:  turn_duration_r <= cfg_data;
          dsp_pkg::CFG_TURN_MODE:      turn_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  dsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item), .cmd(cmd), .sts(sts), .res(res), .res_n(res_n)
  );

  dsp_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_item(in_item),
    .turn_speed(turn_speed_r), .straight_speed(straight_speed_r),
    .turn_duration(turn_duration_r), .turn_mode(turn_mode_r),
    .res(res), .res_n(res_n)
  );
endmodule

// ===== dv/tb_distance_steering_policy.sv =====
`timescale 1ns / 1ps
module tb_distance_steering_policy;
  localparam int DEPTH = dsp_pkg::WINDOW_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dsp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dsp_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  bit stim_done = 1'b0;

  distance_steering_policy i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  class steering_scoreboard;
    logic [7:0] turn_speed = 8'd1;
    logic [7:0] straight_speed = 8'd3;
    logic [7:0] turn_duration = 8'd30;
    logic turn_mode = 1'b0;
    logic [9:0] lwin[DEPTH];
    logic [9:0] rwin[DEPTH];
    int lcnt, rcnt, lpos, rpos;
    int lsum, rsum;
    int front = 200;
    bit halted = 1'b1;
    bit slow = 1'b0;
    bit armed = 1'b0;
    dsp_pkg::out_item_t pending[$];
    int errors = 0;

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        dsp_pkg::CFG_TURN_SPEED:     turn_speed = val;
        dsp_pkg::CFG_STRAIGHT_SPEED: straight_speed = val;
        dsp_pkg::CFG_TURN_DURATION:  turn_duration = val;
        dsp_pkg::CFG_TURN_MODE:      turn_mode = val[0];
        default: ;
      endcase
    endfunction

    function void add_cmd(logic [1:0] tg, logic [1:0] mc, logic [3:0] sc, int arg);
      dsp_pkg::out_item_t c;
      c.target = tg;
      c.motor_command = mc;
      c.servo_command = sc;
      c.argument = arg[9:0];
      c.last = 1'b0;
      pending.push_back(c);
    endfunction

    function dsp_pkg::out_item_t next_expected();
      dsp_pkg::out_item_t e;
      e = pending[0];
      pending.delete(0);
      return e;
    endfunction

    function bit bool_dep(int rd, int avg);
      int d;
      d = rd > avg ? rd - avg : avg - rd;
      return 10 * d > 3 * avg;
    endfunction

    function int newest(bit right);
      if (right) return rcnt == 0 ? 0 : rwin[(rpos + DEPTH - 1) % DEPTH];
      return lcnt == 0 ? 0 : lwin[(lpos + DEPTH - 1) % DEPTH];
    endfunction

    function void push_side(bit right, int m);
      if (right) begin
        if (rcnt >= DEPTH) rsum -= rwin[rpos]; else rcnt++;
        rwin[rpos] = 10'(m);
        rsum += m;
        rpos = (rpos + 1) % DEPTH;
      end else begin
        if (lcnt >= DEPTH) lsum -= lwin[lpos]; else lcnt++;
        lwin[lpos] = 10'(m);
        lsum += m;
        lpos = (lpos + 1) % DEPTH;
      end
    endfunction

    function void side_event(bit right, int m);
      int l, r, la, ra;
      push_side(right, m);
      if ((right ? lcnt : rcnt) == 0) return;
      l = right ? newest(1'b0) : m;
      r = right ? m : newest(1'b1);
      la = lsum / lcnt;
      ra = rsum / rcnt;
      if (l + r > 0 && (bool_dep(r, ra) || bool_dep(l, la)) && front < 60) begin
        if (r > l) add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                           turn_mode ? dsp_pkg::SV_3PT_R : dsp_pkg::SV_TURN_R,
                           turn_mode ? 0 : turn_duration);
        else add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                     turn_mode ? dsp_pkg::SV_3PT_L : dsp_pkg::SV_TURN_L,
                     turn_mode ? 0 : turn_duration);
        return;
      end
      if (m >= 1 && m <= 10)
        add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                right ? dsp_pkg::SV_NUDGE_L : dsp_pkg::SV_NUDGE_R, 0);
    endfunction

    function void front_event(int m);
      if (m == 0) return;
      front = m;
      if (m <= 11) begin
        add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_BACK, dsp_pkg::SV_CENTER, turn_speed);
        add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP,
                newest(1'b0) > newest(1'b1) ? dsp_pkg::SV_RIGHT : dsp_pkg::SV_LEFT, 50);
        add_cmd(dsp_pkg::TGT_TIMER, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, 1000);
        armed = 1'b1;
      end
      if (m < 70 && !slow) begin
        slow = 1'b1;
        add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_FWD, dsp_pkg::SV_CENTER, turn_speed);
      end else if (m >= 70 && slow) begin
        slow = 1'b0;
        add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_FWD, dsp_pkg::SV_CENTER, straight_speed);
      end
    endfunction

    function void note_event(dsp_pkg::in_item_t it);
      int before_n;
      before_n = pending.size();
      case (it.opcode)
        dsp_pkg::OP_STOP: begin
          add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, 0);
          halted = 1'b1;
        end
        dsp_pkg::OP_START: begin
          lcnt = 0; rcnt = 0; lpos = 0; rpos = 0; lsum = 0; rsum = 0;
          front = 200;
          add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, 0);
          add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_START, dsp_pkg::SV_CENTER,
                  straight_speed);
          halted = 1'b0;
        end
        dsp_pkg::OP_TIMER: if (armed) begin
          add_cmd(dsp_pkg::TGT_MOTOR, dsp_pkg::MOT_FWD, dsp_pkg::SV_CENTER, turn_speed);
          add_cmd(dsp_pkg::TGT_SERVO, dsp_pkg::MOT_STOP, dsp_pkg::SV_CENTER, 0);
          armed = 1'b0;
        end
        default: begin
          if ((it.motor_direction == dsp_pkg::DIR_FWD ||
               it.motor_direction == dsp_pkg::DIR_BACK) &&
              it.servo_activity != dsp_pkg::SERVO_OTHER && !halted) begin
            if (it.sensor == dsp_pkg::SENS_LEFT) side_event(1'b0, it.distance);
            else if (it.sensor == dsp_pkg::SENS_RIGHT) side_event(1'b1, it.distance);
            else if (it.sensor == dsp_pkg::SENS_FRONT) front_event(it.distance);
          end
        end
      endcase
      if (pending.size() > before_n) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_cmd(dsp_pkg::out_item_t got);
      dsp_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected beat %p", got);
        errors++;
        return;
      end
      e = next_expected();
      if (got.target !== e.target) begin
        $error("target exp %0d got %0d", e.target, got.target); errors++;
      end
      if (got.motor_command !== e.motor_command) begin
        $error("motor_command exp %0d got %0d", e.motor_command, got.motor_command);
        errors++;
      end
      if (got.servo_command !== e.servo_command) begin
        $error("servo_command exp %0d got %0d", e.servo_command, got.servo_command);
        errors++;
      end
      if (got.argument !== e.argument) begin
        $error("argument exp %0d got %0d", e.argument, got.argument); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  steering_scoreboard sb = new();

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_event(dsp_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_event(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function dsp_pkg::in_item_t mk(logic [1:0] op, logic [1:0] s, int d, logic [1:0] dir,
                                 logic [1:0] sa);
    dsp_pkg::in_item_t it;
    it.opcode = op;
    it.sensor = s;
    it.distance = d[9:0];
    it.motor_direction = dir;
    it.servo_activity = sa;
    return it;
  endfunction

  function dsp_pkg::in_item_t rand_event();
    dsp_pkg::in_item_t it;
    int r;
    it = 16'($urandom());
    r = $urandom_range(0, 99);
    if (r < 80) begin
      it.opcode = dsp_pkg::OP_SAMPLE;
      it.motor_direction = 2'($urandom_range(1, 2));
      it.servo_activity = 2'($urandom_range(0, 2));
      it.sensor = 2'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: it.distance = 10'($urandom_range(0, 12));
        1: it.distance = 10'($urandom_range(40, 90));
        2: it.distance = 10'($urandom_range(0, 120));
        default: it.distance = 10'($urandom());
      endcase
    end else if (r < 84) it.opcode = dsp_pkg::OP_STOP;
    else if (r < 88) it.opcode = dsp_pkg::OP_START;
    else if (r < 93) it.opcode = dsp_pkg::OP_TIMER;
    return it;
  endfunction

  // receiver: random stalls, sampled at rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_cmd(out_item);
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = pick_gap();
      if (gap == 0) out_ready <= 1'b1;
      else begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    send_event(mk(dsp_pkg::OP_TIMER, dsp_pkg::SENS_LEFT, 0, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 5, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_START, dsp_pkg::SENS_LEFT, 0, 2'd0, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 1023, 2'd0, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 1023, dsp_pkg::DIR_FWD,
                  dsp_pkg::SERVO_OTHER));
    send_event(mk(dsp_pkg::OP_SAMPLE, 2'd3, 5, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 11, dsp_pkg::DIR_BACK, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 0, dsp_pkg::DIR_FWD, 2'd1));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_LEFT, 5, dsp_pkg::DIR_FWD, 2'd2));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_RIGHT, 1023, dsp_pkg::DIR_FWD, 2'd1));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_RIGHT, 10, dsp_pkg::DIR_BACK, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 10, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_LEFT, 0, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_LEFT, 1, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_TIMER, dsp_pkg::SENS_FRONT, 0, 2'd0, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 70, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 69, dsp_pkg::DIR_FWD, 2'd0));
    send_event(mk(dsp_pkg::OP_STOP, 2'd3, 1023, 2'd3, 2'd3));
    send_event(mk(dsp_pkg::OP_SAMPLE, dsp_pkg::SENS_FRONT, 5, dsp_pkg::DIR_FWD, 2'd0));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(dsp_pkg::CFG_TURN_SPEED, 8'd255);
          write_reg(dsp_pkg::CFG_STRAIGHT_SPEED, 8'd0);
          write_reg(dsp_pkg::CFG_TURN_DURATION, 8'd255);
          write_reg(dsp_pkg::CFG_TURN_MODE, 8'd1);
        end
        1: begin
          write_reg(dsp_pkg::CFG_TURN_SPEED, 8'd0);
          write_reg(dsp_pkg::CFG_STRAIGHT_SPEED, 8'd255);
          write_reg(dsp_pkg::CFG_TURN_DURATION, 8'd0);
          write_reg(dsp_pkg::CFG_TURN_MODE, 8'd0);
        end
        default: begin
          write_reg(dsp_pkg::CFG_TURN_SPEED, 8'($urandom()));
          write_reg(dsp_pkg::CFG_STRAIGHT_SPEED, 8'($urandom()));
          write_reg(dsp_pkg::CFG_TURN_DURATION, 8'($urandom()));
          write_reg(dsp_pkg::CFG_TURN_MODE, 8'($urandom()));
        end
      endcase
      cfg_valid <= 1'b0;
      send_event(mk(dsp_pkg::OP_START, dsp_pkg::SENS_LEFT, 0, dsp_pkg::DIR_FWD, 2'd0));
      for (int k = 0; k < 25; k++) send_event(rand_event());
      wait_idle();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0) $display("tb_distance_steering_policy: clean");
    else $display("tb_distance_steering_policy: errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_distance_steering_policy: errors");
    $finish;
  end
endmodule
